[hdl/psfc_pkg.sv]
`default_nettype none
package psfc_pkg;

	localparam int unsigned SampleBits = 32;
	localparam int unsigned WidthBits  = 3;
	localparam int unsigned AddrBits   = 5;
	localparam int unsigned DataBits   = 32;

	// register map, one word per register
	typedef enum logic [2:0] {
		REG_SOURCE_WIDTH   = 3'd0,
		REG_SOURCE_FLAG    = 3'd1,
		REG_DEST_WIDTH     = 3'd2,
		REG_DEST_FLAG      = 3'd3,
		REG_SCALE_24_IN_32 = 3'd4
	} reg_index_t;

	localparam logic [WidthBits-1:0] SourceWidthReset = 3'd2;
	localparam logic [WidthBits-1:0] DestWidthReset   = 3'd2;

	// format settings handed to the datapath
	typedef struct packed {
		logic [WidthBits-1:0] source_width;
		logic                 source_flag;
		logic [WidthBits-1:0] dest_width;
		logic                 dest_flag;
		logic                 scale_24_in_32;
	} format_cfg_t;

	// zero maps to one byte, anything above four to four
	function automatic logic [WidthBits-1:0] clamp_width(input logic [WidthBits-1:0] w);
		logic [WidthBits-1:0] r;
		if (w == 3'd0) begin
			r = 3'd1;
		end else if (w > 3'd4) begin
			r = 3'd4;
		end else begin
			r = w;
		end
		return r;
	endfunction

	// keep the low w bytes
	function automatic logic [SampleBits-1:0] mask_bytes(input logic [SampleBits-1:0] v,
			input logic [WidthBits-1:0] w);
		logic [SampleBits-1:0] r;
		case (w)
			3'd1: r = {24'h0, v[7:0]};
			3'd2: r = {16'h0, v[15:0]};
			3'd3: r = {8'h0, v[23:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	// reverse the byte order within the low w bytes
	function automatic logic [SampleBits-1:0] reverse_bytes(input logic [SampleBits-1:0] v,
			input logic [WidthBits-1:0] w);
		logic [SampleBits-1:0] r;
		case (w)
			3'd1: r = {24'h0, v[7:0]};
			3'd2: r = {16'h0, v[7:0], v[15:8]};
			3'd3: r = {8'h0, v[7:0], v[15:8], v[23:16]};
			default: r = {v[7:0], v[15:8], v[23:16], v[31:24]};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/psfc_convert.sv]
`default_nettype none
module psfc_convert (
	input  wire psfc_pkg::format_cfg_t cfg,
	input  wire logic [psfc_pkg::SampleBits-1:0] source_sample,
	output logic [psfc_pkg::SampleBits-1:0] dest_sample
);
	import psfc_pkg::*;

	logic [WidthBits-1:0]  sw;
	logic [WidthBits-1:0]  dw;
	logic [WidthBits-1:0]  sw2;
	logic [WidthBits-1:0]  dw2;
	logic [WidthBits-1:0]  grow;
	logic [WidthBits-1:0]  shrink;
	logic [SampleBits-1:0] raw;
	logic [SampleBits-1:0] val;
	logic [SampleBits-1:0] scaled;
	logic [SampleBits-1:0] sized;
	logic [7:0]            quot;
	logic                  src_u8;
	logic                  dst_u8;
	logic                  pass;

	assign sw  = clamp_width(cfg.source_width);
	assign dw  = clamp_width(cfg.dest_width);
	assign raw = mask_bytes(source_sample, sw);

	// copy, byte-swapped where the orders differ, when the formats differ at most in byte order
	assign pass = (sw == dw) && ((cfg.source_flag == cfg.dest_flag) || (dw >= 3'd2));

	assign src_u8 = (sw == 3'd1) && !cfg.source_flag;
	assign dst_u8 = (dw == 3'd1) && !cfg.dest_flag;

	// numeric value of the source, offset-binary bytes widened to 16 bits
	always_comb begin
		if (src_u8) begin
			val = {16'h0, raw[7:0] ^ 8'h80, 8'h00};
			sw2 = 3'd2;
		end else if (sw == 3'd1) begin
			val = raw;
			sw2 = 3'd1;
		end else begin
			val = cfg.source_flag ? reverse_bytes(raw, sw) : raw;
			sw2 = sw;
		end
	end

	// optional x256 on a 4-byte source
	assign scaled = (cfg.scale_24_in_32 && (sw2 == 3'd4)) ? {val[23:0], 8'h00} : val;

	// resize by whole bytes, keeping the top bytes
	assign dw2    = dst_u8 ? 3'd2 : dw;
	assign grow   = dw2 - sw2;
	assign shrink = sw2 - dw2;

	always_comb begin
		if (dw2 > sw2) begin
			sized = mask_bytes(scaled << {grow[1:0], 3'b000}, dw2);
		end else if (sw2 > dw2) begin
			sized = mask_bytes(scaled >> {shrink[1:0], 3'b000}, dw2);
		end else begin
			sized = mask_bytes(scaled, dw2);
		end
	end

	// signed 16-bit divided by 256 toward zero
	assign quot = sized[15:8] + {7'h0, sized[15] & (|sized[7:0])};

	// final byte order or offset-binary encoding
	always_comb begin
		if (pass) begin
			dest_sample = (cfg.source_flag != cfg.dest_flag) ? reverse_bytes(raw, sw) : raw;
		end else if (dst_u8) begin
			dest_sample = {24'h0, quot ^ 8'h80};
		end else if ((dw >= 3'd2) && cfg.dest_flag) begin
			dest_sample = reverse_bytes(sized, dw);
		end else begin
			dest_sample = sized;
		end
	end

endmodule
`default_nettype wire

[hdl/pcm_sample_format_converter_core.sv]
`default_nettype none
// a request taken into the input register is converted and shown (done high) from the result register
// throughput: one sample per clock, set by the combinational conversion stage; busy stays low
// the receiver cannot stall, so every result is shown for exactly one cycle
// reset clears the pipeline valid flags and loads the default format: 2-byte little-endian
// in and out, scale off
module pcm_sample_format_converter_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [psfc_pkg::SampleBits-1:0] source_sample,
	input  wire logic final_sample,
	output logic done,
	output logic [psfc_pkg::SampleBits-1:0] dest_sample,
	output logic final_out,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [psfc_pkg::AddrBits-1:0] paddr,
	input  wire logic [psfc_pkg::DataBits-1:0] pwdata,
	output logic [psfc_pkg::DataBits-1:0] prdata,
	output logic pready
);
	import psfc_pkg::*;

	format_cfg_t           cfg_q;
	reg_index_t            reg_sel;
	logic                  wr_en;
	logic                  valid_s1;
	logic [SampleBits-1:0] sample_s1;
	logic                  final_s1;
	logic [SampleBits-1:0] conv;
	logic                  valid_s2;
	logic [SampleBits-1:0] sample_s2;
	logic                  final_s2;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// register file
	assign reg_sel = reg_index_t'(paddr[AddrBits-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_width   <= SourceWidthReset;
			cfg_q.source_flag    <= 1'b0;
			cfg_q.dest_width     <= DestWidthReset;
			cfg_q.dest_flag      <= 1'b0;
			cfg_q.scale_24_in_32 <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_SOURCE_WIDTH:   cfg_q.source_width   <= pwdata[WidthBits-1:0];
				REG_SOURCE_FLAG:    cfg_q.source_flag    <= pwdata[0];
				REG_DEST_WIDTH:     cfg_q.dest_width     <= pwdata[WidthBits-1:0];
				REG_DEST_FLAG:      cfg_q.dest_flag      <= pwdata[0];
				REG_SCALE_24_IN_32: cfg_q.scale_24_in_32 <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_SOURCE_WIDTH:   prdata[WidthBits-1:0] = cfg_q.source_width;
			REG_SOURCE_FLAG:    prdata[0]             = cfg_q.source_flag;
			REG_DEST_WIDTH:     prdata[WidthBits-1:0] = cfg_q.dest_width;
			REG_DEST_FLAG:      prdata[0]             = cfg_q.dest_flag;
			REG_SCALE_24_IN_32: prdata[0]             = cfg_q.scale_24_in_32;
			default: ;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			sample_s1 <= source_sample;
			final_s1  <= final_sample;
		end
	end

	// conversion datapath
	psfc_convert u_convert (
		.cfg           (cfg_q),
		.source_sample (sample_s1),
		.dest_sample   (conv)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sample_s2 <= conv;
			final_s2  <= final_s1;
		end
	end

	assign done        = valid_s2;
	assign dest_sample = sample_s2;
	assign final_out   = final_s2;

endmodule
`default_nettype wire

[test/tb_pcm_sample_format_converter_core.sv]
`default_nettype none
module tb_pcm_sample_format_converter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import psfc_pkg::*;

	localparam int unsigned QuietLimit = 1000;
	localparam int unsigned SettleCycles = 4;

	typedef struct {
		logic [SampleBits-1:0] dest;
		logic                  fin;
	} converted_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [SampleBits-1:0] source_sample = '0;
	logic                  final_sample = 1'b0;
	logic                  done;
	logic [SampleBits-1:0] dest_sample;
	logic                  final_out;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [AddrBits-1:0]   paddr = '0;
	logic [DataBits-1:0]   pwdata = '0;
	logic [DataBits-1:0]   prdata;
	logic                  pready;

	// local copy of the format registers, at their reset values
	logic [WidthBits-1:0] src_width_q = 3'd2;
	logic                 src_flag_q = 1'b0;
	logic [WidthBits-1:0] dst_width_q = 3'd2;
	logic                 dst_flag_q = 1'b0;
	logic                 scale_q = 1'b0;

	converted_t  pending_samples[$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_on = 1'b1;

	pcm_sample_format_converter_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.source_sample(source_sample),
		.final_sample(final_sample),
		.done(done),
		.dest_sample(dest_sample),
		.final_out(final_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// byte count actually used for a width setting
	function automatic int unsigned byte_count(input logic [WidthBits-1:0] w);
		if (w == 0) begin
			return 1;
		end
		if (w > 4) begin
			return 4;
		end
		return w;
	endfunction

	function automatic logic [31:0] keep_low(input logic [31:0] v, input int unsigned n);
		if (n >= 4) begin
			return v;
		end
		return v & ((32'h1 << (8 * n)) - 32'h1);
	endfunction

	function automatic logic [31:0] flip_order(input logic [31:0] v, input int unsigned n);
		logic [31:0] r;
		r = '0;
		for (int unsigned i = 0; i < n; i++) begin
			r = (r << 8) | {24'h0, v[8*i +: 8]};
		end
		return r;
	endfunction

	// expected destination bytes for one source sample under the current format
	function automatic logic [31:0] convert_sample(input logic [31:0] sample);
		int unsigned        sw;
		int unsigned        dw;
		int unsigned        sw2;
		int unsigned        dw2;
		logic [31:0]        raw;
		logic [31:0]        v;
		logic [31:0]        res;
		logic signed [15:0] s16;
		int                 q;
		bit                 src_u8;
		bit                 dst_u8;
		sw = byte_count(src_width_q);
		dw = byte_count(dst_width_q);
		raw = keep_low(sample, sw);
		if (sw == dw && (src_flag_q == dst_flag_q || dw >= 2)) begin
			res = (src_flag_q != dst_flag_q) ? flip_order(raw, sw) : raw;
		end else begin
			src_u8 = (sw == 1 && !src_flag_q);
			dst_u8 = (dw == 1 && !dst_flag_q);
			// numeric value in source byte width
			if (src_u8) begin
				v = {16'h0, raw[7:0] ^ 8'h80, 8'h00};
				sw2 = 2;
			end else if (sw == 1) begin
				v = raw;
				sw2 = 1;
			end else begin
				v = src_flag_q ? flip_order(raw, sw) : raw;
				sw2 = sw;
			end
			if (scale_q && sw2 == 4) begin
				v = v << 8;
			end
			// resize by whole bytes
			dw2 = dst_u8 ? 2 : dw;
			if (dw2 > sw2) begin
				v = v << (8 * (dw2 - sw2));
			end else if (sw2 > dw2) begin
				v = v >> (8 * (sw2 - dw2));
			end
			v = keep_low(v, dw2);
			if (dst_u8) begin
				s16 = v[15:0];
				q = s16 / 256 + 128;
				res = {24'h0, q[7:0]};
			end else if (dw >= 2 && dst_flag_q) begin
				res = flip_order(v, dw);
			end else begin
				res = v;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// predict on each accepted request, check each result, watch for a hang
	always @(posedge clk) begin : sample_monitor
		converted_t want;
		if (arst_n) begin
			if (start && !busy) begin
				want.dest = convert_sample(source_sample);
				want.fin = final_sample;
				pending_samples.push_back(want);
			end
			if (done) begin
				if (pending_samples.size() == 0) begin
					report_mismatch("result with no request", dest_sample, '0);
				end else begin
					want = pending_samples.pop_front();
					if (dest_sample !== want.dest) begin
						report_mismatch("dest_sample", dest_sample, want.dest);
					end
					if (final_out !== want.fin) begin
						report_mismatch("final_out", {31'h0, final_out}, {31'h0, want.fin});
					end
				end
			end
			if ((start && !busy) || done || (psel && penable && pwrite && pready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QuietLimit) begin
				$display("tb_pcm_sample_format_converter_core: FAIL");
				$finish;
			end
		end
	end

	// one request, with a random gap before it when idling is on
	task automatic send_sample(input logic [31:0] sample, input logic fin);
		if (idle_on && $urandom_range(0, 99) < 33) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 1)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		source_sample <= sample;
		final_sample <= fin;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	// stop sending and wait for every outstanding result
	task automatic wait_drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [DataBits-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		case (idx)
			REG_SOURCE_WIDTH: src_width_q = value[WidthBits-1:0];
			REG_SOURCE_FLAG: src_flag_q = value[0];
			REG_DEST_WIDTH: dst_width_q = value[WidthBits-1:0];
			REG_DEST_FLAG: dst_flag_q = value[0];
			REG_SCALE_24_IN_32: scale_q = value[0];
			default: ;
		endcase
	endtask

	// new format, written only once the block has gone quiet
	task automatic set_format(input logic [2:0] sw, input logic sf, input logic [2:0] dw,
			input logic df, input logic sc);
		logic [DataBits-1:0] noise;
		wait_drain();
		noise = $urandom;
		write_reg(REG_SOURCE_WIDTH, {noise[31:3], sw});
		noise = $urandom;
		write_reg(REG_SOURCE_FLAG, {noise[31:1], sf});
		noise = $urandom;
		write_reg(REG_DEST_WIDTH, {noise[31:3], dw});
		noise = $urandom;
		write_reg(REG_DEST_FLAG, {noise[31:1], df});
		noise = $urandom;
		write_reg(REG_SCALE_24_IN_32, {noise[31:1], sc});
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8080_8080;
			3: return 32'h7F7F_7F7F;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_width();
		if ($urandom_range(0, 4) == 0) begin
			return 3'($urandom_range(0, 7));
		end
		return 3'($urandom_range(1, 4));
	endfunction

	// default 2-byte little-endian pass-through, upper bytes ignored
	task automatic test_reset_format();
		send_sample(32'hFFFF_8000, 1'b0);
		send_sample(32'h0000_7FFF, 1'b1);
		send_sample(32'h0000_0000, 1'b0);
	endtask

	// each conversion path and corner once
	task automatic test_conversions();
		// equal widths with differing order: swap, scale ignored
		set_format(3'd2, 1'b0, 3'd2, 1'b1, 1'b1);
		send_sample(32'hAABB_1234, 1'b1);
		// offset-binary byte to 16 bits
		set_format(3'd1, 1'b0, 3'd2, 1'b0, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'h0000_0080, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1);
		// 16 bits to offset-binary byte, truncation toward zero
		set_format(3'd2, 1'b0, 3'd1, 1'b0, 1'b0);
		send_sample(32'h0000_8000, 1'b0);
		send_sample(32'h0000_7FFF, 1'b0);
		send_sample(32'h0000_FF01, 1'b0);
		send_sample(32'h0000_0100, 1'b1);
		// scale with big-endian on both sides
		set_format(3'd4, 1'b1, 3'd3, 1'b1, 1'b1);
		send_sample(32'h1122_3344, 1'b0);
		// widths out of range: zero acts as one byte, seven as four
		set_format(3'd0, 1'b1, 3'd7, 1'b0, 1'b0);
		send_sample(32'hFFFF_FF80, 1'b1);
		// signed byte to offset-binary byte is a real conversion
		set_format(3'd1, 1'b1, 3'd1, 1'b0, 1'b0);
		send_sample(32'h0000_0080, 1'b0);
		send_sample(32'h0000_007F, 1'b0);
		// narrowing a big-endian 3-byte source to a signed byte
		set_format(3'd3, 1'b1, 3'd1, 1'b1, 1'b0);
		send_sample(32'h00C0_FFEE, 1'b1);
		// scaled 4-byte source narrowed to 2 bytes
		set_format(3'd4, 1'b0, 3'd2, 1'b0, 1'b1);
		send_sample(32'h89AB_CDEF, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1);
	endtask

	// random formats with random samples and gaps
	task automatic test_random_formats();
		for (int p = 0; p < 12; p++) begin
			if (p == 0) begin
				set_format(3'd4, 1'b1, 3'd1, 1'b0, 1'b1);
			end else if (p == 1) begin
				set_format(3'd1, 1'b0, 3'd4, 1'b1, 1'b1);
			end else begin
				set_format(pick_width(), 1'($urandom), pick_width(), 1'($urandom),
					1'($urandom));
			end
			for (int i = 0; i < 30; i++) begin
				// hold off mid-phase until the block has drained
				if (p == 3 && i == 15) begin
					wait_drain();
				end
				send_sample(pick_sample(), 1'($urandom));
			end
		end
	endtask

	// a long run with no gaps at all
	task automatic test_back_to_back();
		idle_on = 1'b0;
		set_format(pick_width(), 1'($urandom), pick_width(), 1'($urandom), 1'($urandom));
		for (int i = 0; i < 40; i++) begin
			send_sample(pick_sample(), 1'($urandom));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_format();
		test_conversions();
		test_random_formats();
		test_back_to_back();
		wait_drain();
		if (pending_samples.size() != 0) begin
			report_mismatch("results still missing", '0, 32'(pending_samples.size()));
		end
		if (mismatch_count == 0) begin
			$display("tb_pcm_sample_format_converter_core: PASS");
		end else begin
			$display("tb_pcm_sample_format_converter_core: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
hdl/psfc_pkg.sv
hdl/psfc_convert.sv
hdl/pcm_sample_format_converter_core.sv
test/tb_pcm_sample_format_converter_core.sv
